// File: rtl/svm_pkg.sv
// Shared types, opcodes, error codes and defaults for the stack machine step block.
package svm_pkg;

    localparam int STACK_DEPTH_DEF   = 1024;
    localparam int PROGRAM_LINES_DEF = 512;

    localparam int OP_W       = 5;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int LINE_OUT_W = 9;
    localparam int ERR_W      = 3;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 48;
    localparam int DIV_STEPS  = 32;

    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd2;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_ADDR  = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 5'd0,
        OP_ALLOC  = 5'd1,
        OP_DALLOC = 5'd2,
        OP_HLT    = 5'd3,
        OP_LDC    = 5'd4,
        OP_LDV    = 5'd5,
        OP_ADD    = 5'd6,
        OP_SUB    = 5'd7,
        OP_MULT   = 5'd8,
        OP_DIVI   = 5'd9,
        OP_INV    = 5'd10,
        OP_AND    = 5'd11,
        OP_OR     = 5'd12,
        OP_NEG    = 5'd13,
        OP_CME    = 5'd14,
        OP_CMA    = 5'd15,
        OP_CEQ    = 5'd16,
        OP_CDIF   = 5'd17,
        OP_CMEQ   = 5'd18,
        OP_CMAQ   = 5'd19,
        OP_JMP    = 5'd20,
        OP_JMPF   = 5'd21,
        OP_NULL   = 5'd22,
        OP_STR    = 5'd23,
        OP_RD     = 5'd24,
        OP_PRN    = 5'd25,
        OP_CALL   = 5'd26,
        OP_RETURN = 5'd27
    } svm_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_READ2,
        S_EXEC,
        S_DIV,
        S_DIVWB,
        S_CPRD,
        S_CPWR,
        S_CPFIN
    } svm_state_t;

    typedef struct packed {
        logic in_ready;
        logic latch;
        logic clr_step;
        logic rd_top;
        logic rd_second;
        logic cap_y;
        logic commit;
        logic div_start;
        logic copy_init;
        logic copy_rd;
        logic copy_wr;
        logic line_adv;
        logic load_out;
    } svm_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic finish_now;
        logic is_div;
        logic copy_last;
        logic div_done;
        logic out_busy;
    } svm_stat_t;

endpackage

// File: rtl/stack_vm_instruction_step.sv
// Top level of the stack machine instruction step block.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   one instruction request
//  m_*      out  m_tvalid/m_tready   one step result per request
//
// After reset the data stack is swept to zero, one cell a cycle, and no request is
// taken during that pass.
// Most instructions go through accept, top-of-stack read, second read and execute.
// DIVI adds a pass through the bit-serial divider; ALLOC and DALLOC add a copy
// loop, one read and one write of the stack memory per cell, then a finish step.
// A result waits in the output register; the next request is taken meanwhile and
// its execute step holds while the previous result is still unread.
module stack_vm_instruction_step
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int PROGRAM_LINES = PROGRAM_LINES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // operand_first[31:0], operand_second[42:32], read_value[74:43], zeros above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // req_type[4:0]
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // next_line[8:0], print_value[40:9], halted[41], error_code[44:42], zeros above
    output logic [OUT_DATA_W-1:0] m_tdata,
    // print_valid[0]
    output logic                  m_tuser
);

    svm_cmd_t  cmd;
    svm_stat_t st;

    svm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .st       (st),
        .cmd      (cmd)
    );

    svm_dpath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .PROGRAM_LINES (PROGRAM_LINES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .st       (st),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign s_tready = cmd.in_ready;

endmodule

// File: rtl/svm_div.sv
// Radix-2 restoring signed divider, truncating toward zero, one quotient bit per cycle.
module svm_div
    import svm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] quotient
);

    localparam int SW = $clog2(DIV_STEPS);

    logic              busy_reg;
    logic              done_reg;
    logic [SW-1:0]     step_reg;
    logic [WORD_W-1:0] q_reg;
    logic [WORD_W-1:0] r_reg;
    logic [WORD_W-1:0] d_reg;
    logic              neg_reg;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   diff;

    assign trial = {r_reg, q_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Magnitudes are unsigned, so the most negative dividend is handled as 2^31.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            d_reg   <= divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            r_reg   <= '0;
            neg_reg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[WORD_W])
            begin
                r_reg <= diff[WORD_W-1:0];
                q_reg <= {q_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial[WORD_W-1:0];
                q_reg <= {q_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

// File: rtl/svm_ctrl.sv
// Sequencing state machine for one instruction step.
module svm_ctrl
    import svm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    input  svm_stat_t st,
    output svm_cmd_t  cmd
);

    svm_state_t state_reg;
    svm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_READ2;
            S_READ2: state_next = S_EXEC;
            S_EXEC:
            begin
                if (!st.out_busy)
                begin
                    if (st.finish_now)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (st.is_div)
                    begin
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_CPRD;
                    end
                end
            end
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_DIVWB;
                end
            end
            S_DIVWB:
            begin
                if (!st.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            S_CPRD: state_next = S_CPWR;
            S_CPWR: state_next = st.copy_last ? S_CPFIN : S_CPRD;
            S_CPFIN:
            begin
                if (!st.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_CLEAR: cmd.clr_step = 1'b1;
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.latch    = s_tvalid;
            end
            S_READ: cmd.rd_top = 1'b1;
            S_READ2:
            begin
                cmd.cap_y     = 1'b1;
                cmd.rd_second = 1'b1;
            end
            S_EXEC:
            begin
                if (!st.out_busy)
                begin
                    if (st.finish_now)
                    begin
                        cmd.commit   = 1'b1;
                        cmd.load_out = 1'b1;
                    end
                    else if (st.is_div)
                    begin
                        cmd.div_start = 1'b1;
                    end
                    else
                    begin
                        cmd.copy_init = 1'b1;
                    end
                end
            end
            S_DIVWB:
            begin
                if (!st.out_busy)
                begin
                    cmd.commit   = 1'b1;
                    cmd.load_out = 1'b1;
                end
            end
            S_CPRD: cmd.copy_rd = 1'b1;
            S_CPWR: cmd.copy_wr = 1'b1;
            S_CPFIN:
            begin
                if (!st.out_busy)
                begin
                    cmd.line_adv = 1'b1;
                    cmd.load_out = 1'b1;
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

// File: rtl/svm_dpath.sv
// Datapath: data stack memory, stack pointer, line counter, checks and result register.
module svm_dpath
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
    parameter int PROGRAM_LINES = PROGRAM_LINES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  svm_cmd_t              cmd,
    output svm_stat_t             st,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int LW = $clog2(PROGRAM_LINES);
    localparam int EW = (CW > COUNT_W) ? CW + 1 : COUNT_W + 1;
    localparam int XW = (LW > LINE_OUT_W) ? LW : LINE_OUT_W;

    logic [WORD_W-1:0] mem [STACK_DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    svm_op_t            op_reg;
    logic [WORD_W-1:0]  a_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [WORD_W-1:0]  rv_reg;
    logic [WORD_W-1:0]  y_reg;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_d;
    logic [LW-1:0]      line_reg;
    logic [LW-1:0]      line_d;
    logic               halt_reg;
    logic               halt_d;
    logic [AW-1:0]      clr_reg;
    logic [AW-1:0]      ptr_reg;
    logic [COUNT_W-1:0] left_reg;

    logic                  out_valid_reg;
    logic [LINE_OUT_W-1:0] out_line_reg;
    logic                  out_pvalid_reg;
    logic [WORD_W-1:0]     out_pval_reg;
    logic                  out_halt_reg;
    logic [ERR_W-1:0]      out_err_reg;

    logic [WORD_W-1:0] x;
    logic [CW-1:0]     cm1;
    logic [CW-1:0]     cm2;
    logic [AW-1:0]     a_lo;
    logic              addr_ok;
    logic              tgt_ok;
    logic              ret_ok;
    logic              blk_ok;
    logic [WORD_W:0]   blk_end;
    logic              is_binary;
    logic              is_alloc;
    logic [ERR_W-1:0]  err;
    logic [WORD_W-1:0] r;
    logic [2*WORD_W-1:0] prod;
    logic              commit_ok;
    logic              pvalid;
    logic [LW-1:0]     line_inc;
    logic [XW-1:0]     line_ext;

    logic              wen;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              ren;
    logic [AW-1:0]     raddr;

    logic              div_done;
    logic [WORD_W-1:0] div_q;

    svm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (x),
        .divisor  (y_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign x        = rdata_reg;
    assign cm1      = cnt_reg - CW'(1);
    assign cm2      = cnt_reg - CW'(2);
    assign a_lo     = a_reg[AW-1:0];
    assign addr_ok  = !a_reg[WORD_W-1] && (a_reg < WORD_W'(STACK_DEPTH));
    assign tgt_ok   = !a_reg[WORD_W-1] && (a_reg != '0) && (a_reg <= WORD_W'(PROGRAM_LINES));
    assign ret_ok   = !y_reg[WORD_W-1] && (y_reg != '0) && (y_reg <= WORD_W'(PROGRAM_LINES));
    assign blk_end  = {1'b0, a_reg} + (WORD_W + 1)'(n_reg);
    assign blk_ok   = (n_reg == '0) ||
                      (!a_reg[WORD_W-1] && (blk_end <= (WORD_W + 1)'(STACK_DEPTH)));
    assign is_binary = op_reg inside {OP_ADD, OP_SUB, OP_MULT, OP_DIVI, OP_AND, OP_OR,
                                      OP_CME, OP_CMA, OP_CEQ, OP_CDIF, OP_CMEQ, OP_CMAQ};
    assign is_alloc = (op_reg == OP_ALLOC);
    assign prod     = x * y_reg;
    assign line_inc = (line_reg == LW'(PROGRAM_LINES - 1)) ? '0 : line_reg + LW'(1);

    // Checks in the order the machine defines; cells read above the top are never trusted
    // before the depth check has passed.
    always_comb
    begin
        err = ERR_NONE;
        case (op_reg)
            OP_START, OP_HLT, OP_NULL: err = ERR_NONE;
            OP_ALLOC:
            begin
                if (!blk_ok)
                    err = ERR_BAD_ADDR;
                else if (EW'(cnt_reg) + EW'(n_reg) > EW'(STACK_DEPTH))
                    err = ERR_OVERFLOW;
            end
            OP_DALLOC:
            begin
                if (!blk_ok)
                    err = ERR_BAD_ADDR;
                else if (EW'(n_reg) > EW'(cnt_reg))
                    err = ERR_UNDERFLOW;
            end
            OP_LDC, OP_RD:
            begin
                if (cnt_reg >= CW'(STACK_DEPTH))
                    err = ERR_OVERFLOW;
            end
            OP_LDV:
            begin
                if (!addr_ok)
                    err = ERR_BAD_ADDR;
                else if (cnt_reg >= CW'(STACK_DEPTH))
                    err = ERR_OVERFLOW;
            end
            OP_ADD, OP_SUB, OP_MULT, OP_AND, OP_OR,
            OP_CME, OP_CMA, OP_CEQ, OP_CDIF, OP_CMEQ, OP_CMAQ:
            begin
                if (cnt_reg < CW'(2))
                    err = ERR_UNDERFLOW;
            end
            OP_DIVI:
            begin
                if (cnt_reg < CW'(2))
                    err = ERR_UNDERFLOW;
                else if (y_reg == '0)
                    err = ERR_DIV_ZERO;
            end
            OP_INV, OP_NEG, OP_PRN:
            begin
                if (cnt_reg == '0)
                    err = ERR_UNDERFLOW;
            end
            OP_JMP:
            begin
                if (!tgt_ok)
                    err = ERR_BAD_ADDR;
            end
            OP_JMPF:
            begin
                if (cnt_reg == '0)
                    err = ERR_UNDERFLOW;
                else if ((y_reg == '0) && !tgt_ok)
                    err = ERR_BAD_ADDR;
            end
            OP_STR:
            begin
                if (!addr_ok)
                    err = ERR_BAD_ADDR;
                else if (cnt_reg == '0)
                    err = ERR_UNDERFLOW;
            end
            OP_CALL:
            begin
                if (cnt_reg >= CW'(STACK_DEPTH))
                    err = ERR_OVERFLOW;
                else if (!tgt_ok)
                    err = ERR_BAD_ADDR;
            end
            OP_RETURN:
            begin
                if (cnt_reg == '0)
                    err = ERR_UNDERFLOW;
                else if (!ret_ok)
                    err = ERR_BAD_ADDR;
            end
            default: err = ERR_BAD_ADDR;
        endcase
    end

    always_comb
    begin
        r = '0;
        case (op_reg)
            OP_ADD:  r = x + y_reg;
            OP_SUB:  r = x - y_reg;
            OP_MULT: r = prod[WORD_W-1:0];
            OP_DIVI: r = div_q;
            OP_AND:  r = WORD_W'((x == WORD_W'(1)) && (y_reg == WORD_W'(1)));
            OP_OR:   r = WORD_W'((x == WORD_W'(1)) || (y_reg == WORD_W'(1)));
            OP_CME:  r = WORD_W'($signed(x) < $signed(y_reg));
            OP_CMA:  r = WORD_W'($signed(x) > $signed(y_reg));
            OP_CEQ:  r = WORD_W'(x == y_reg);
            OP_CDIF: r = WORD_W'(x != y_reg);
            OP_CMEQ: r = WORD_W'($signed(x) <= $signed(y_reg));
            OP_CMAQ: r = WORD_W'($signed(x) >= $signed(y_reg));
            default: r = '0;
        endcase
    end

    assign commit_ok = cmd.commit && !halt_reg && (err == ERR_NONE);

    always_comb
    begin
        wen    = 1'b0;
        waddr  = '0;
        wdata  = '0;
        cnt_d  = cnt_reg;
        line_d = line_reg;
        halt_d = halt_reg;
        pvalid = 1'b0;
        if (cmd.clr_step)
        begin
            wen   = 1'b1;
            waddr = clr_reg;
        end
        else if (cmd.copy_wr)
        begin
            wen   = 1'b1;
            wdata = rdata_reg;
            if (is_alloc)
            begin
                waddr = cnt_reg[AW-1:0];
                cnt_d = cnt_reg + CW'(1);
            end
            else
            begin
                waddr = ptr_reg;
                cnt_d = cm1;
            end
        end
        else if (cmd.line_adv)
        begin
            line_d = line_inc;
        end
        else if (commit_ok)
        begin
            line_d = line_inc;
            case (op_reg)
                OP_START: cnt_d = '0;
                OP_HLT:   halt_d = 1'b1;
                OP_LDC, OP_LDV, OP_RD:
                begin
                    wen   = 1'b1;
                    waddr = cnt_reg[AW-1:0];
                    wdata = (op_reg == OP_LDC) ? a_reg :
                            (op_reg == OP_LDV) ? x : rv_reg;
                    cnt_d = cnt_reg + CW'(1);
                end
                OP_ADD, OP_SUB, OP_MULT, OP_DIVI, OP_AND, OP_OR,
                OP_CME, OP_CMA, OP_CEQ, OP_CDIF, OP_CMEQ, OP_CMAQ:
                begin
                    wen   = 1'b1;
                    waddr = cm2[AW-1:0];
                    wdata = r;
                    cnt_d = cm1;
                end
                OP_INV:
                begin
                    wen   = 1'b1;
                    waddr = cm1[AW-1:0];
                    wdata = '0 - y_reg;
                end
                OP_NEG:
                begin
                    wen   = 1'b1;
                    waddr = cm1[AW-1:0];
                    wdata = WORD_W'(y_reg == '0);
                end
                OP_JMP: line_d = LW'(a_reg - WORD_W'(1));
                OP_JMPF:
                begin
                    if (y_reg == '0)
                        line_d = LW'(a_reg - WORD_W'(1));
                    cnt_d = cm1;
                end
                OP_STR:
                begin
                    wen   = 1'b1;
                    waddr = a_lo;
                    wdata = y_reg;
                    cnt_d = cm1;
                end
                OP_PRN:
                begin
                    pvalid = 1'b1;
                    cnt_d  = cm1;
                end
                OP_CALL:
                begin
                    wen    = 1'b1;
                    waddr  = cnt_reg[AW-1:0];
                    wdata  = WORD_W'(line_reg) + WORD_W'(2);
                    cnt_d  = cnt_reg + CW'(1);
                    line_d = LW'(a_reg - WORD_W'(1));
                end
                OP_RETURN:
                begin
                    line_d = LW'(y_reg - WORD_W'(1));
                    cnt_d  = cm1;
                end
                default: line_d = line_inc;
            endcase
        end
    end

    always_comb
    begin
        ren   = 1'b1;
        raddr = cm1[AW-1:0];
        if (cmd.rd_second)
            raddr = is_binary ? cm2[AW-1:0] : a_lo;
        else if (cmd.copy_rd)
            raddr = is_alloc ? ptr_reg : cm1[AW-1:0];
        else if (!cmd.rd_top)
            ren = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wen)
            mem[waddr] <= wdata;
        if (ren)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= svm_op_t'(s_tuser);
            a_reg  <= s_tdata[31:0];
            n_reg  <= s_tdata[42:32];
            rv_reg <= s_tdata[74:43];
        end
        if (cmd.cap_y)
            y_reg <= rdata_reg;
        if (cmd.copy_init)
        begin
            ptr_reg  <= is_alloc ? a_lo : AW'(a_lo + AW'(n_reg) - AW'(1));
            left_reg <= n_reg;
        end
        else if (cmd.copy_wr)
        begin
            ptr_reg  <= is_alloc ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
            left_reg <= left_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            line_reg <= '0;
            halt_reg <= 1'b0;
            clr_reg  <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_d;
            line_reg <= line_d;
            halt_reg <= halt_d;
            if (cmd.clr_step)
                clr_reg <= clr_reg + AW'(1);
        end
    end

    assign line_ext = XW'(line_d);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_line_reg   <= line_ext[LINE_OUT_W-1:0];
            out_pvalid_reg <= pvalid;
            out_pval_reg   <= pvalid ? y_reg : '0;
            out_halt_reg   <= halt_d;
            out_err_reg    <= (halt_reg || cmd.line_adv) ? ERR_NONE : err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_pvalid_reg;
    assign m_tdata  = {3'b000, out_err_reg, out_halt_reg, out_pval_reg, out_line_reg};

    assign st.clr_done   = (clr_reg == AW'(STACK_DEPTH - 1));
    // A zero count only short-cuts the block copies; DIVI runs the divider unless halted or in error.
    assign st.finish_now = halt_reg || (err != ERR_NONE) ||
                           !(op_reg inside {OP_DIVI, OP_ALLOC, OP_DALLOC}) ||
                           ((op_reg != OP_DIVI) && (n_reg == '0));
    assign st.is_div     = (op_reg == OP_DIVI);
    assign st.copy_last  = (left_reg == COUNT_W'(1));
    assign st.div_done   = div_done;
    assign st.out_busy   = out_valid_reg && !m_tready;

endmodule

// File: sim/tb_stack_vm_instruction_step.sv
// Self-checking testbench for the stack machine instruction step block.
`timescale 1ns / 1ps

module tb_stack_vm_instruction_step;
    import svm_pkg::*;

    localparam int DEPTH = 1024;
    localparam int LINES = 512;
    localparam int CYCLE_LIMIT = 10000000;

    typedef struct packed {
        logic [8:0]  next_line;
        logic        print_valid;
        logic [31:0] print_value;
        logic        halted;
        logic [2:0]  error_code;
    } step_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;

    // Machine state as the block should hold it.
    logic [31:0] vm_cells [DEPTH];
    int unsigned vm_count;
    logic [8:0] vm_line;
    logic vm_halt;

    step_result_t pending_steps[$];
    int errors = 0;
    int requests_sent = 0;
    int results_seen = 0;
    int cycles = 0;
    bit sink_stalls = 1'b1;
    bit source_gaps = 1'b1;

    stack_vm_instruction_step dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL stack_vm_instruction_step");
            $finish;
        end
    end

    function automatic logic line_valid(longint t);
        return t >= 1 && t <= LINES;
    endfunction

    // Executes one instruction on the model state and returns the expected result.
    function automatic step_result_t execute_step(svm_op_t op, logic [31:0] opa,
                                                  logic [10:0] cnt, logic [31:0] rv);
        step_result_t r;
        logic [2:0] err;
        logic [8:0] nl;
        logic pv;
        logic [31:0] pval, x, y, res;
        longint a, t;
        int unsigned k;
        r = '0;
        err = ERR_NONE;
        pv = 1'b0;
        pval = '0;
        res = '0;
        a = longint'(signed'(opa));
        nl = (vm_line + 9'd1) % LINES;
        if (vm_halt)
        begin
            r.next_line = vm_line;
            r.halted = 1'b1;
            return r;
        end
        case (op)
            OP_START: vm_count = 0;
            OP_ALLOC, OP_DALLOC:
            begin
                if (cnt != 0 && (a < 0 || a + cnt > DEPTH))
                    err = ERR_BAD_ADDR;
                else if (op == OP_ALLOC && vm_count + cnt > DEPTH)
                    err = ERR_OVERFLOW;
                else if (op == OP_DALLOC && cnt > vm_count)
                    err = ERR_UNDERFLOW;
                else if (op == OP_ALLOC)
                    for (k = 0; k < cnt; k++)
                    begin
                        vm_cells[vm_count] = vm_cells[a + k];
                        vm_count++;
                    end
                else
                    for (k = cnt; k > 0; k--)
                    begin
                        vm_cells[a + k - 1] = vm_cells[vm_count - 1];
                        vm_count--;
                    end
            end
            OP_HLT: vm_halt = 1'b1;
            OP_LDC, OP_LDV, OP_RD:
            begin
                if (op == OP_LDV && (a < 0 || a >= DEPTH))
                    err = ERR_BAD_ADDR;
                else if (vm_count >= DEPTH)
                    err = ERR_OVERFLOW;
                else
                begin
                    vm_cells[vm_count] = (op == OP_LDC) ? opa :
                                         (op == OP_LDV) ? vm_cells[a] : rv;
                    vm_count++;
                end
            end
            OP_ADD, OP_SUB, OP_MULT, OP_DIVI, OP_AND, OP_OR,
            OP_CME, OP_CMA, OP_CEQ, OP_CDIF, OP_CMEQ, OP_CMAQ:
            begin
                if (vm_count < 2)
                    err = ERR_UNDERFLOW;
                else
                begin
                    x = vm_cells[vm_count - 2];
                    y = vm_cells[vm_count - 1];
                    case (op)
                        OP_ADD:  res = x + y;
                        OP_SUB:  res = x - y;
                        OP_MULT: res = x * y;
                        OP_DIVI:
                            if (y == 0) err = ERR_DIV_ZERO;
                            else res = 32'(longint'(signed'(x)) / longint'(signed'(y)));
                        OP_AND:  res = 32'(x == 1 && y == 1);
                        OP_OR:   res = 32'(x == 1 || y == 1);
                        OP_CME:  res = 32'(signed'(x) < signed'(y));
                        OP_CMA:  res = 32'(signed'(x) > signed'(y));
                        OP_CEQ:  res = 32'(x == y);
                        OP_CDIF: res = 32'(x != y);
                        OP_CMEQ: res = 32'(signed'(x) <= signed'(y));
                        default: res = 32'(signed'(x) >= signed'(y));
                    endcase
                    if (err == ERR_NONE)
                    begin
                        vm_cells[vm_count - 2] = res;
                        vm_count--;
                    end
                end
            end
            OP_INV, OP_NEG:
            begin
                if (vm_count < 1)
                    err = ERR_UNDERFLOW;
                else if (op == OP_INV)
                    vm_cells[vm_count - 1] = -vm_cells[vm_count - 1];
                else
                    vm_cells[vm_count - 1] = 32'(vm_cells[vm_count - 1] == 0);
            end
            OP_JMP:
                if (!line_valid(a)) err = ERR_BAD_ADDR;
                else nl = 9'(a - 1);
            OP_JMPF:
            begin
                if (vm_count < 1)
                    err = ERR_UNDERFLOW;
                else if (vm_cells[vm_count - 1] == 0 && !line_valid(a))
                    err = ERR_BAD_ADDR;
                else
                begin
                    if (vm_cells[vm_count - 1] == 0)
                        nl = 9'(a - 1);
                    vm_count--;
                end
            end
            OP_NULL: ;
            OP_STR:
            begin
                if (a < 0 || a >= DEPTH)
                    err = ERR_BAD_ADDR;
                else if (vm_count < 1)
                    err = ERR_UNDERFLOW;
                else
                begin
                    vm_cells[a] = vm_cells[vm_count - 1];
                    vm_count--;
                end
            end
            OP_PRN:
            begin
                if (vm_count < 1)
                    err = ERR_UNDERFLOW;
                else
                begin
                    pv = 1'b1;
                    pval = vm_cells[vm_count - 1];
                    vm_count--;
                end
            end
            OP_CALL:
            begin
                if (vm_count >= DEPTH)
                    err = ERR_OVERFLOW;
                else if (!line_valid(a))
                    err = ERR_BAD_ADDR;
                else
                begin
                    vm_cells[vm_count] = 32'(vm_line) + 32'd2;
                    vm_count++;
                    nl = 9'(a - 1);
                end
            end
            OP_RETURN:
            begin
                if (vm_count < 1)
                    err = ERR_UNDERFLOW;
                else
                begin
                    t = longint'(signed'(vm_cells[vm_count - 1]));
                    if (!line_valid(t))
                        err = ERR_BAD_ADDR;
                    else
                    begin
                        nl = 9'(t - 1);
                        vm_count--;
                    end
                end
            end
            default: err = ERR_BAD_ADDR;
        endcase
        if (err != ERR_NONE)
        begin
            pv = 1'b0;
            pval = '0;
        end
        else
            vm_line = nl;
        r.next_line = vm_line;
        r.print_valid = pv;
        r.print_value = pval;
        r.halted = vm_halt;
        r.error_code = err;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch on result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
    endtask

    // Result checker and sink stall generator.
    initial
    begin : result_checker
        step_result_t want;
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_steps.size() == 0)
                    report_mismatch("unexpected result", m_tdata, 0);
                else
                begin
                    want = pending_steps.pop_front();
                    if (m_tdata[8:0] !== want.next_line)
                        report_mismatch("next_line", m_tdata[8:0], want.next_line);
                    if (m_tuser !== want.print_valid)
                        report_mismatch("print_valid", m_tuser, want.print_valid);
                    if (m_tdata[40:9] !== want.print_value)
                        report_mismatch("print_value", m_tdata[40:9], want.print_value);
                    if (m_tdata[41] !== want.halted)
                        report_mismatch("halted", m_tdata[41], want.halted);
                    if (m_tdata[44:42] !== want.error_code)
                        report_mismatch("error_code", m_tdata[44:42], want.error_code);
                    if (m_tdata[47:45] !== 3'b000)
                        report_mismatch("padding", m_tdata[47:45], 0);
                end
                results_seen++;
            end
            if (stall > 0 && sink_stalls)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Sends one request; the expected result is computed at acceptance.
    // The valid line stays high after acceptance unless a gap or a drain follows.
    task automatic send_request(svm_op_t op, logic [31:0] opa, logic [10:0] cnt,
                                logic [31:0] rv);
        int gap;
        if (source_gaps && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'd0, rv, cnt, opa};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_steps.push_back(execute_step(op, opa, cnt, rv));
        requests_sent++;
    endtask

    task automatic send_raw(logic [4:0] code, logic [31:0] opa, logic [10:0] cnt,
                            logic [31:0] rv);
        send_request(svm_op_t'(code), opa, cnt, rv);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_steps.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return $urandom_range(0, 3);
            4: return $urandom_range(1, LINES);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return DEPTH;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, DEPTH - 1);
        endcase
    endfunction

    task automatic test_directed();
        send_request(OP_PRN, 0, 0, 0);                 // underflow on empty stack
        send_request(OP_ADD, 0, 0, 0);
        send_request(OP_LDC, 32'h8000_0000, 0, 0);
        send_request(OP_LDC, 32'hFFFF_FFFF, 0, 0);
        send_request(OP_DIVI, 0, 0, 0);                // most negative by minus one
        send_request(OP_PRN, 0, 0, 0);
        send_request(OP_LDC, 7, 0, 0);
        send_request(OP_LDC, 0, 0, 0);
        send_request(OP_DIVI, 0, 0, 0);                // divide by zero
        send_request(OP_RD, 0, 0, 32'h7FFF_FFFF);
        send_request(OP_STR, DEPTH - 1, 0, 0);
        send_request(OP_LDV, DEPTH, 0, 0);             // address out of range
        send_request(OP_LDV, DEPTH - 1, 0, 0);
        send_request(OP_ALLOC, 1020, 5, 0);            // block past the end
        send_request(OP_ALLOC, 0, 0, 0);               // zero count no-op
        send_request(OP_DALLOC, 0, 11'd1024, 0);       // underflow
        send_request(OP_JMP, 0, 0, 0);
        send_request(OP_JMP, LINES, 0, 0);
        send_request(OP_CALL, 513, 0, 0);
        send_request(OP_CALL, 1, 0, 0);
        send_request(OP_RETURN, 0, 0, 0);
        send_request(OP_JMPF, 32'h8000_0000, 0, 0);    // not taken, target unchecked
        send_raw(5'd31, 0, 0, 0);                      // unknown opcode
        send_request(OP_START, 0, 0, 0);
    endtask

    task automatic test_stack_limits();
        int i;
        // Fill to the top with one block copy, then push once more.
        send_request(OP_ALLOC, 0, 11'd1024, 0);
        send_request(OP_LDC, 1, 0, 0);
        send_request(OP_CALL, 5, 0, 0);
        send_request(OP_DALLOC, 0, 11'd1024, 0);
        for (i = 0; i < 4; i++)
            send_request(OP_LDC, $urandom, 0, 0);
        wait_drained();                                 // sender holds until drained
        send_request(OP_START, 0, 0, 0);
    endtask

    task automatic test_random(int total, logic [4:0] top_code);
        int i;
        logic [4:0] code;
        logic [10:0] cnt;
        for (i = 0; i < total; i++)
        begin
            code = $urandom_range(0, top_code);
            cnt = ($urandom_range(0, 30) == 0) ? 11'($urandom_range(0, 1024))
                                               : 11'($urandom_range(0, 6));
            if (code == OP_HLT && $urandom_range(0, 3) != 0)
                code = OP_NULL;
            if (vm_count > 900 && $urandom_range(0, 1) == 0)
                code = OP_START;
            case (code)
                OP_LDV, OP_STR, OP_ALLOC, OP_DALLOC:
                    send_raw(code, pick_addr(), cnt, $urandom);
                default:
                    send_raw(code, pick_word(), cnt, pick_word());
            endcase
        end
    endtask

    initial
    begin : stimulus
        int i;
        for (i = 0; i < DEPTH; i++)
            vm_cells[i] = '0;
        vm_count = 0;
        vm_line = '0;
        vm_halt = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_stack_limits();
        test_random(500, 5'd27);
        test_random(500, 5'd31);
        sink_stalls = 1'b0;
        source_gaps = 1'b0;
        test_random(250, 5'd27);
        send_request(OP_HLT, 0, 0, 0);
        for (i = 0; i < 8; i++)
            send_raw(5'($urandom), $urandom, 11'($urandom_range(0, 1024)), $urandom);
        wait_drained();
        repeat (50) @(posedge clk);
        $display("%0d requests sent and %0d results checked, covering every opcode,",
                 requests_sent, results_seen);
        $display("stack and line limits, division corner cases, and halt.");
        if (errors == 0 && pending_steps.size() == 0)
            $display("PASS stack_vm_instruction_step");
        else
            $display("FAIL stack_vm_instruction_step");
        $finish;
    end

endmodule
